// ----- rtl/blsc_pkg.sv -----
// blsc_pkg: shared types and constants for the line stepper core
// no dependencies
package blsc_pkg;

  localparam int COORD_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 2;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_NEXT  = 1'b1
  } cmd_e;

  // decoded command word passed from front to back
  typedef struct packed {
    cmd_e   op;
    coord_t sx;
    coord_t sy;
    coord_t major;
    coord_t minor;
    err_t   err_init;
    logic   dir_x_neg;
    logic   dir_y_neg;
    logic   x_major;
  } cmd_t;

  // result word
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
    logic   none;
  } res_t;

endpackage

// ----- rtl/blsc_front.sv -----
// blsc_front: classifies incoming words and decodes line endpoints
// depends on blsc_pkg
module blsc_front (
  input  logic            in_command,
  input  blsc_pkg::coord_t in_start_x,
  input  blsc_pkg::coord_t in_start_y,
  input  blsc_pkg::coord_t in_end_x,
  input  blsc_pkg::coord_t in_end_y,
  output blsc_pkg::cmd_t   cmd
);
  import blsc_pkg::*;

  logic   dxn, dyn, xm;
  coord_t adx, ady, maj, mnr;

  always_comb begin
    dxn = in_end_x < in_start_x;
    dyn = in_end_y < in_start_y;
    adx = dxn ? in_start_x - in_end_x : in_end_x - in_start_x;
    ady = dyn ? in_start_y - in_end_y : in_end_y - in_start_y;
    xm  = adx > ady;
    maj = xm ? adx : ady;
    mnr = xm ? ady : adx;

    cmd.op        = (in_command == CMD_NEXT) ? CMD_NEXT : CMD_START;
    cmd.sx        = in_start_x;
    cmd.sy        = in_start_y;
    cmd.major     = maj;
    cmd.minor     = mnr;
    // twice-scale decision variable: 2*minor - major
    cmd.err_init  = $signed({1'b0, mnr, 1'b0}) - $signed({2'b00, maj});
    cmd.dir_x_neg = dxn;
    cmd.dir_y_neg = dyn;
    cmd.x_major   = xm;
  end

endmodule

// ----- rtl/blsc_cmd_queue.sv -----
// blsc_cmd_queue: two-entry queue of decoded commands between front and back
// depends on blsc_pkg
module blsc_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  blsc_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output blsc_pkg::cmd_t head
);
  import blsc_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full    = count_r == 2'd2;
  assign empty   = count_r == 2'd0;
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/blsc_back.sv -----
// blsc_back: line stepping engine with a two-entry result queue
// depends on blsc_pkg
module blsc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_empty,
  input  blsc_pkg::cmd_t   cmd,
  output logic             cmd_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output blsc_pkg::coord_t out_pixel_x,
  output blsc_pkg::coord_t out_pixel_y,
  output logic             out_is_last,
  output logic             out_no_line
);
  import blsc_pkg::*;

  coord_t cur_x_r, cur_x_nxt;
  coord_t cur_y_r, cur_y_nxt;
  err_t   err_r, err_nxt;
  coord_t major_r, major_nxt;
  coord_t minor_r, minor_nxt;
  logic   dxn_r, dxn_nxt;
  logic   dyn_r, dyn_nxt;
  logic   xm_r, xm_nxt;
  coord_t steps_r, steps_nxt;
  logic   busy_r, busy_nxt;

  res_t       res_mem_r [2];
  logic       res_wr_r, res_rd_r;
  logic [1:0] res_cnt_r, res_cnt_nxt;
  logic       res_push, res_pop;
  res_t       res;

  logic                step_minor;
  logic [ERR_BITS:0]   err_ext;

  assign cmd_pop = !cmd_empty && (res_cnt_r != 2'd2);
  assign res_push = cmd_pop;

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    err_nxt    = err_r;
    major_nxt  = major_r;
    minor_nxt  = minor_r;
    dxn_nxt    = dxn_r;
    dyn_nxt    = dyn_r;
    xm_nxt     = xm_r;
    steps_nxt  = steps_r;
    busy_nxt   = busy_r;
    step_minor = !err_r[ERR_BITS-1];
    err_ext    = '0;
    res        = '0;

    case (cmd.op)
      CMD_START: begin
        cur_x_nxt = cmd.sx;
        cur_y_nxt = cmd.sy;
        err_nxt   = cmd.err_init;
        major_nxt = cmd.major;
        minor_nxt = cmd.minor;
        dxn_nxt   = cmd.dir_x_neg;
        dyn_nxt   = cmd.dir_y_neg;
        xm_nxt    = cmd.x_major;
        steps_nxt = cmd.major;
        busy_nxt  = cmd.major != '0;
        res.x     = cmd.sx;
        res.y     = cmd.sy;
        res.last  = cmd.major == '0;
        res.none  = 1'b0;
      end
      CMD_NEXT: begin
        if (!busy_r) begin
          res.none = 1'b1;
        end else begin
          // major axis always steps, minor axis when the error is not negative
          if (xm_r || step_minor) begin
            cur_x_nxt = dxn_r ? cur_x_r - coord_t'(1) : cur_x_r + coord_t'(1);
          end
          if (!xm_r || step_minor) begin
            cur_y_nxt = dyn_r ? cur_y_r - coord_t'(1) : cur_y_r + coord_t'(1);
          end
          err_ext = {err_r[ERR_BITS-1], err_r}
                    - (step_minor ? {2'b00, major_r, 1'b0} : '0)
                    + {2'b00, minor_r, 1'b0};
          err_nxt   = $signed(err_ext[ERR_BITS-1:0]);
          steps_nxt = steps_r - coord_t'(1);
          busy_nxt  = steps_nxt != '0;
          res.x     = cur_x_nxt;
          res.y     = cur_y_nxt;
          res.last  = steps_nxt == '0;
          res.none  = 1'b0;
        end
      end
      default: begin
        res.none = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd_pop) begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      err_r   <= err_nxt;
      major_r <= major_nxt;
      minor_r <= minor_nxt;
      dxn_r   <= dxn_nxt;
      dyn_r   <= dyn_nxt;
      xm_r    <= xm_nxt;
      steps_r <= steps_nxt;
    end
  end

  // result queue
  assign res_pop     = out_pop && (res_cnt_r != 2'd0);
  assign out_empty   = res_cnt_r == 2'd0;
  assign out_pixel_x = res_mem_r[res_rd_r].x;
  assign out_pixel_y = res_mem_r[res_rd_r].y;
  assign out_is_last = res_mem_r[res_rd_r].last;
  assign out_no_line = res_mem_r[res_rd_r].none;
  assign res_cnt_nxt = res_cnt_r + {1'b0, res_push} - {1'b0, res_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r  <= 1'b0;
      res_rd_r  <= 1'b0;
      res_cnt_r <= 2'd0;
    end else begin
      res_wr_r  <= res_push ? ~res_wr_r : res_wr_r;
      res_rd_r  <= res_pop ? ~res_rd_r : res_rd_r;
      res_cnt_r <= res_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem_r[res_wr_r] <= res;
    end
  end

endmodule

// ----- rtl/bresenham_line_stepper_core.sv -----
// bresenham_line_stepper_core: line rasterizer, one pixel word per command word
// depends on blsc_pkg, blsc_front, blsc_cmd_queue, blsc_back
//
// input channel: push a command word while full is low; command start loads
// both endpoints and returns the start pixel, command next returns the
// following pixel along the line, the endpoint flagged by is_last. a next
// with no line loaded returns no_line with zero coordinates.
// result channel: while empty is low the oldest pixel word is on the out_
// ports; pop takes it. every command word yields exactly one result word.
// a command word is decoded before the edge that accepts it into the
// command queue; the back end steps it as it pops it from that queue and
// writes the result word into the result queue that drives the out_ ports.
// throughput: one word per cycle while neither queue stalls; the engine's error
// update is one add, one compare and one subtract in combinational logic.
// stalls: a two-entry command queue and a two-entry result queue let the
// sides stall on their own; with pop held low the engine stops when the
// result queue fills, and full rises once the command queue fills too.
// reset: synchronous active-low rst_n empties both queues and drops any line.
module bresenham_line_stepper_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic             in_command,
  input  blsc_pkg::coord_t in_start_x,
  input  blsc_pkg::coord_t in_start_y,
  input  blsc_pkg::coord_t in_end_x,
  input  blsc_pkg::coord_t in_end_y,
  output logic             empty,
  input  logic             pop,
  output blsc_pkg::coord_t out_pixel_x,
  output blsc_pkg::coord_t out_pixel_y,
  output logic             out_is_last,
  output logic             out_no_line
);
  import blsc_pkg::*;

  cmd_t dec_cmd;
  cmd_t q_head;
  logic q_empty;
  logic q_pop;

  blsc_front u_front (
    .in_command (in_command),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .cmd        (dec_cmd)
  );

  blsc_cmd_queue u_cmd_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (dec_cmd),
    .full      (full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  blsc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_empty   (q_empty),
    .cmd         (q_head),
    .cmd_pop     (q_pop),
    .out_empty   (empty),
    .out_pop     (pop),
    .out_pixel_x (out_pixel_x),
    .out_pixel_y (out_pixel_y),
    .out_is_last (out_is_last),
    .out_no_line (out_no_line)
  );

endmodule

// ----- bench/bresenham_line_stepper_core_test.sv -----
// bresenham_line_stepper_core_test: self-checking bench for the line stepper core
// drives command words through the push/full queue, checks pixel words popped
// from the result queue against typed words or a line predictor; needs blsc_pkg
module bresenham_line_stepper_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import blsc_pkg::*;

  typedef struct {
    cmd_e   op;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   typed;
    res_t   want;
  } row_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   push = 1'b0;
  logic   full;
  logic   in_command = 1'b0;
  coord_t in_start_x = '0;
  coord_t in_start_y = '0;
  coord_t in_end_x = '0;
  coord_t in_end_y = '0;
  logic   empty;
  logic   pop = 1'b0;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  logic   out_is_last;
  logic   out_no_line;

  bresenham_line_stepper_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_command(in_command),
    .in_start_x(in_start_x),
    .in_start_y(in_start_y),
    .in_end_x(in_end_x),
    .in_end_y(in_end_y),
    .empty(empty),
    .pop(pop),
    .out_pixel_x(out_pixel_x),
    .out_pixel_y(out_pixel_y),
    .out_is_last(out_is_last),
    .out_no_line(out_no_line)
  );

  always #5 clk = ~clk;

  // line tracker state
  coord_t cur_px = '0;
  coord_t cur_py = '0;
  int     decision = 0;
  coord_t span_x = '0;
  coord_t span_y = '0;
  logic   down_x = 1'b0;
  logic   down_y = 1'b0;
  logic   wide = 1'b0;
  coord_t remaining = '0;
  logic   drawing = 1'b0;

  res_t pending_pixels[$];
  row_t dir_rows[$];

  int mismatches = 0;
  int words_sent = 0;
  int lines_started = 0;
  int ends_seen = 0;
  int no_line_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int burst_left = 0;
  int hold_cnt = 0;
  bit hold_req = 0;

  function automatic res_t step_line(cmd_e op, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    res_t r;
    r.x = '0;
    r.y = '0;
    r.last = 1'b0;
    r.none = 1'b0;
    if (op == CMD_START) begin
      down_x = ex < sx;
      down_y = ey < sy;
      span_x = down_x ? sx - ex : ex - sx;
      span_y = down_y ? sy - ey : ey - sy;
      wide = span_x > span_y;
      if (wide) begin
        decision = 2 * int'(span_y) - int'(span_x);
        remaining = span_x;
      end else begin
        decision = 2 * int'(span_x) - int'(span_y);
        remaining = span_y;
      end
      cur_px = sx;
      cur_py = sy;
      drawing = remaining != 0;
    end else if (!drawing) begin
      r.none = 1'b1;
      return r;
    end else begin
      if (wide) begin
        if (decision >= 0) begin
          cur_py = down_y ? cur_py - coord_t'(1) : cur_py + coord_t'(1);
          decision -= 2 * int'(span_x);
        end
        cur_px = down_x ? cur_px - coord_t'(1) : cur_px + coord_t'(1);
        decision += 2 * int'(span_y);
      end else begin
        if (decision >= 0) begin
          cur_px = down_x ? cur_px - coord_t'(1) : cur_px + coord_t'(1);
          decision -= 2 * int'(span_y);
        end
        cur_py = down_y ? cur_py - coord_t'(1) : cur_py + coord_t'(1);
        decision += 2 * int'(span_x);
      end
      remaining = remaining - coord_t'(1);
      drawing = remaining != 0;
    end
    r.x = cur_px;
    r.y = cur_py;
    r.last = remaining == 0;
    return r;
  endfunction

  function automatic void add_row(cmd_e op, int sx, int sy, int ex, int ey, int typed,
                                  int wx, int wy, int wl, int wn);
    row_t r;
    r.op = op;
    r.sx = coord_t'(sx);
    r.sy = coord_t'(sy);
    r.ex = coord_t'(ex);
    r.ey = coord_t'(ey);
    r.typed = typed != 0;
    r.want.x = coord_t'(wx);
    r.want.y = coord_t'(wy);
    r.want.last = wl != 0;
    r.want.none = wn != 0;
    dir_rows.push_back(r);
  endfunction

  function automatic coord_t far_end(coord_t s, int d);
    if ($urandom_range(0, 1) == 1 && int'(s) >= d) return s - coord_t'(d);
    if (int'(s) + d <= 4095) return s + coord_t'(d);
    return s - coord_t'(d);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic send_word(cmd_e op, coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                           logic typed, res_t want);
    res_t predicted;
    while (burst_left == 0 && $urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    if (burst_left != 0) burst_left--;
    push <= 1'b1;
    in_command <= op;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x <= ex;
    in_end_y <= ey;
    @(posedge clk);
    while (full) @(posedge clk);
    predicted = step_line(op, sx, sy, ex, ey);
    pending_pixels.push_back(typed ? want : predicted);
    words_sent++;
    if (op == CMD_START) lines_started++;
  endtask

  task automatic send_next();
    res_t none;
    none = '0;
    send_word(CMD_NEXT, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), 1'b0, none);
  endtask

  task automatic check_pixel();
    res_t want;
    if (pending_pixels.size() == 0) begin
      report_mismatch("unexpected pixel word", 1, 0);
      return;
    end
    want = pending_pixels.pop_front();
    if (out_pixel_x !== want.x)
      report_mismatch("pixel_x", int'(out_pixel_x), int'(want.x));
    if (out_pixel_y !== want.y)
      report_mismatch("pixel_y", int'(out_pixel_y), int'(want.y));
    if (out_is_last !== want.last)
      report_mismatch("is_last", int'(out_is_last), int'(want.last));
    if (out_no_line !== want.none)
      report_mismatch("no_line", int'(out_no_line), int'(want.none));
    if (out_is_last === 1'b1) ends_seen++;
    if (out_no_line === 1'b1) no_line_seen++;
  endtask

  // result side
  initial begin
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) check_pixel();
      if (hold_req) begin
        hold_cnt = 60;
        hold_req = 0;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        pop <= 1'b0;
      end else begin
        pop <= $urandom_range(0, 99) >= recv_idle_pct;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d pixel words outstanding", pending_pixels.size());
    $display("bresenham_line_stepper_core_test: FAIL");
    $finish;
  end

  // command side
  initial begin
    res_t   none;
    coord_t sx, sy, ex, ey;
    int     dx, dy, steps, lim, kind, n;
    bit     hold_done, drain_done;
    none = '0;
    hold_done = 0;
    drain_done = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    add_row(CMD_NEXT, 4095, 4095, 4095, 4095, 1, 0, 0, 0, 1);
    add_row(CMD_START, 0, 0, 0, 0, 1, 0, 0, 1, 0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 1, 0, 0, 0, 1);
    add_row(CMD_START, 0, 0, 4095, 4095, 1, 0, 0, 0, 0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_NEXT, 4095, 0, 4095, 0, 0, 0, 0, 0, 0);
    add_row(CMD_START, 4095, 4095, 0, 0, 1, 4095, 4095, 0, 0);
    add_row(CMD_NEXT, 0, 4095, 0, 4095, 0, 0, 0, 0, 0);
    add_row(CMD_START, 4095, 0, 0, 4095, 1, 4095, 0, 0, 0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_START, 10, 10, 13, 11, 1, 10, 10, 0, 0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 1, 0, 0, 0, 1);
    add_row(CMD_START, 100, 200, 98, 205, 1, 100, 200, 0, 0);
    repeat (5) add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 1, 0, 0, 0, 1);
    add_row(CMD_START, 2047, 2048, 2048, 2047, 1, 2047, 2048, 0, 0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_START, 2730, 1365, 1365, 2730, 1, 2730, 1365, 0, 0);

    foreach (dir_rows[i])
      send_word(dir_rows[i].op, dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex,
                dir_rows[i].ey, dir_rows[i].typed, dir_rows[i].want);

    while (words_sent < 1450) begin
      if (words_sent < 500) begin
        send_idle_pct = 34;
        recv_idle_pct = 66;
      end else if (words_sent < 980) begin
        send_idle_pct = 66;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (words_sent >= 300 && !hold_done) begin
        hold_done = 1;
        hold_req = 1;
        burst_left = 14;
      end
      if (words_sent >= 800 && !drain_done) begin
        drain_done = 1;
        push <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
      end
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        // well-formed line, mostly short
        lim = ($urandom_range(0, 99) < 3) ? 200 : 16;
        dx = $urandom_range(0, lim);
        dy = $urandom_range(0, lim);
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        ex = far_end(sx, dx);
        ey = far_end(sy, dy);
        steps = (dx > dy) ? dx : dy;
        send_word(CMD_START, sx, sy, ex, ey, 1'b0, none);
        n = $urandom_range(0, 99);
        if (n < 15) steps += $urandom_range(1, 3);
        else if (n < 25 && steps > 0) steps = $urandom_range(0, steps - 1);
        repeat (steps) send_next();
      end else if (kind < 90) begin
        // far endpoints, dropped after a few pixels
        send_word(CMD_START, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), 1'b0, none);
        repeat ($urandom_range(0, 5)) send_next();
      end else begin
        repeat ($urandom_range(1, 4))
          send_word(cmd_e'($urandom_range(0, 1)), coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), coord_t'($urandom), 1'b0, none);
      end
    end

    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d command words over %0d lines, %0d endpoints and %0d no_line words",
             words_sent, lines_started, ends_seen, no_line_seen);
    $display("with queue back-pressure, a long result stall and a full drain; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("bresenham_line_stepper_core_test: PASS");
    end else begin
      $display("bresenham_line_stepper_core_test: FAIL");
    end
    $finish;
  end

endmodule
